@@ hdl/periodic_timer_bank_core_defines.svh @@
// Assertion macros shared by the timer bank RTL.
// Expects signals named clk and arst_n in the scope of use.
`ifndef PERIODIC_TIMER_BANK_CORE_DEFINES_SVH
`define PERIODIC_TIMER_BANK_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PTB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/ptb_pkg.sv @@
// Shared types and constants of the periodic timer bank.
// No dependencies.
package ptb_pkg;

	localparam int TIU_W       = 5;
	localparam int FIELD_W     = 32;
	localparam int OUT_IDX_W   = 4;
	localparam int MAX_RESULTS = 16;
	localparam int RCNT_W      = 5;

	typedef enum logic [1:0] {
		FN_TICK   = 2'd0,
		FN_ARM    = 2'd1,
		FN_DISARM = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	// Sequencer to result stage.
	typedef struct packed {
		logic                 push;
		logic                 flush;
		logic [OUT_IDX_W-1:0] idx;
	} res_req_t;

	// Result stage to sequencer.
	typedef struct packed {
		logic room;
		logic pend;
	} res_sts_t;

endpackage

@@ hdl/periodic_timer_bank_core.sv @@
// Periodic timer bank top level: config register, sequencer, state memories, result stage.
// Depends on ptb_pkg, ptb_mem, ptb_ctrl, ptb_out and the assertion macro header.
//
//   channel   | dir | handshake             | payload
//   ----------+-----+-----------------------+------------------------------------
//   cfg       | in  | cfg_valid / cfg_ready | cfg_data (timers_in_use)
//   in        | in  | in_valid / in_ready   | func, timer_index, timeout, interval
//   out       | out | out_valid / out_ready | expired_timer, last
//
// Arm, disarm and unused codes are taken straight from idle. A tick is accepted,
// then scans min(timers_in_use, NUM_TIMERS) timers and drains the result stage.
// The scan is a one-entry-per-cycle read-modify-write, held while an expiry
// stalls on the result stage, through the single write port of the count memory.
// Reset clears the config register, the sequencer and the per-entry valid bits;
// no clearing pass is needed. A stalled output stops the scan only when an
// expiry finds both the pending word and the output register full.
`include "periodic_timer_bank_core_defines.svh"

module periodic_timer_bank_core import ptb_pkg::*; #(
	parameter int NUM_TIMERS  = 16,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [TIU_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           func,
	input  logic [3:0]           timer_index,
	input  logic [FIELD_W-1:0]   timeout,
	input  logic [FIELD_W-1:0]   interval,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [OUT_IDX_W-1:0] expired_timer,
	output logic                 last
);

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	logic [TIU_W-1:0]       tiu_q;
	logic                   rd_en;
	logic [IDX_W-1:0]       rd_addr;
	logic [COUNT_WIDTH-1:0] rd_rem;
	logic [COUNT_WIDTH-1:0] rd_rld;
	logic                   rem_we;
	logic                   rld_we;
	logic [IDX_W-1:0]       wr_addr;
	logic [COUNT_WIDTH-1:0] wr_rem;
	logic [COUNT_WIDTH-1:0] wr_rld;
	res_req_t               res_req;
	res_sts_t               res_sts;

	// The user must send config writes only while the bank is idle; not enforced here, always take them.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tiu_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			tiu_q <= cfg_data;
		end
	end

	// Sequencer: arm and disarm write straight through, a tick walks the bank.
	ptb_ctrl #(
		.NUM_TIMERS  (NUM_TIMERS),
		.COUNT_WIDTH (COUNT_WIDTH),
		.IDX_W       (IDX_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.timer_index (timer_index),
		.timeout     (timeout),
		.interval    (interval),
		.tiu         (tiu_q),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_rem      (rd_rem),
		.rd_rld      (rd_rld),
		.rem_we      (rem_we),
		.rld_we      (rld_we),
		.wr_addr     (wr_addr),
		.wr_rem      (wr_rem),
		.wr_rld      (wr_rld),
		.res_req     (res_req),
		.res_sts     (res_sts)
	);

	// State memories; the write of entry k overlaps the read of entry k+1 only.
	ptb_mem #(
		.NUM_TIMERS  (NUM_TIMERS),
		.COUNT_WIDTH (COUNT_WIDTH),
		.IDX_W       (IDX_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_rem  (rd_rem),
		.rd_rld  (rd_rld),
		.rem_we  (rem_we),
		.rld_we  (rld_we),
		.wr_addr (wr_addr),
		.wr_rem  (wr_rem),
		.wr_rld  (wr_rld)
	);

	// Hold each expiry until the next one (or the end of the scan) settles last.
	ptb_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.res_req       (res_req),
		.res_sts       (res_sts),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.expired_timer (expired_timer),
		.last          (last)
	);

	// Idle means every word of the previous tick has left the pending slot.
	`PTB_ASSERT_IMP(a_idle_drained, in_ready, !res_sts.pend, "ready with a word still pending")
	// A word is either pushed mid-scan or flushed at the end, never both.
	`PTB_ASSERT_IMP(a_push_xor_flush, res_req.push, !res_req.flush, "push and flush together")
	// A blocked expiry must not commit its reload to memory.
	`PTB_ASSERT_IMP(a_stall_no_write, res_req.push && !res_sts.room, !rem_we,
		"count written back during a stall")

endmodule

@@ hdl/ptb_mem.sv @@
// Timer state memories: remaining count with per-entry valid bits, reload count.
// Depends on ptb_pkg. Registered read.
module ptb_mem import ptb_pkg::*; #(
	parameter int NUM_TIMERS  = 16,
	parameter int COUNT_WIDTH = 32,
	parameter int IDX_W       = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rd_en,
	input  logic [IDX_W-1:0]       rd_addr,
	output logic [COUNT_WIDTH-1:0] rd_rem,
	output logic [COUNT_WIDTH-1:0] rd_rld,
	input  logic                   rem_we,
	input  logic                   rld_we,
	input  logic [IDX_W-1:0]       wr_addr,
	input  logic [COUNT_WIDTH-1:0] wr_rem,
	input  logic [COUNT_WIDTH-1:0] wr_rld
);

	logic [COUNT_WIDTH-1:0] rem_mem [NUM_TIMERS];
	logic [COUNT_WIDTH-1:0] rld_mem [NUM_TIMERS];
	logic [NUM_TIMERS-1:0]  vld_q;
	logic [COUNT_WIDTH-1:0] rem_rd_q;
	logic [COUNT_WIDTH-1:0] rld_rd_q;
	logic                   vld_rd_q;

	always_ff @(posedge clk) begin
		if (rem_we) begin
			rem_mem[wr_addr] <= wr_rem;
		end
		if (rld_we) begin
			rld_mem[wr_addr] <= wr_rld;
		end
	end

	// An entry never written reads as zero (disarmed).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (rem_we) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// Hold read data while the sequencer stalls.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rem_rd_q <= rem_mem[rd_addr];
			rld_rd_q <= rld_mem[rd_addr];
			vld_rd_q <= vld_q[rd_addr];
		end
	end

	assign rd_rem = vld_rd_q ? rem_rd_q : '0;
	assign rd_rld = rld_rd_q;

endmodule

@@ hdl/ptb_ctrl.sv @@
// Sequencer: arm/disarm writes and the read-modify-write scan of a tick.
// Depends on ptb_pkg; drives ptb_mem and the result stage.
module ptb_ctrl import ptb_pkg::*; #(
	parameter int NUM_TIMERS  = 16,
	parameter int COUNT_WIDTH = 32,
	parameter int IDX_W       = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             func,
	input  logic [3:0]             timer_index,
	input  logic [FIELD_W-1:0]     timeout,
	input  logic [FIELD_W-1:0]     interval,
	input  logic [TIU_W-1:0]       tiu,
	output logic                   rd_en,
	output logic [IDX_W-1:0]       rd_addr,
	input  logic [COUNT_WIDTH-1:0] rd_rem,
	input  logic [COUNT_WIDTH-1:0] rd_rld,
	output logic                   rem_we,
	output logic                   rld_we,
	output logic [IDX_W-1:0]       wr_addr,
	output logic [COUNT_WIDTH-1:0] wr_rem,
	output logic [COUNT_WIDTH-1:0] wr_rld,
	output res_req_t               res_req,
	input  res_sts_t               res_sts
);

	state_t            state_q, state_d;
	logic [TIU_W-1:0]  rd_cnt_q;
	logic [TIU_W-1:0]  idx_s1_q;
	logic [RCNT_W-1:0] cnt_q;
	logic [TIU_W-1:0]  scan_len;
	logic              in_acc;
	logic              idx_ok;
	logic              start;
	logic              nz;
	logic              expire;
	logic              push;
	logic              stall;
	logic              advance;
	logic              more;

	always_comb begin
		if (32'(tiu) > NUM_TIMERS) begin
			scan_len = TIU_W'(NUM_TIMERS);
		end else begin
			scan_len = tiu;
		end
	end

	assign in_acc  = in_valid && in_ready;
	assign idx_ok  = 32'(timer_index) < NUM_TIMERS;
	assign start   = in_acc && (func == FN_TICK) && (scan_len != '0);
	assign nz      = |rd_rem;
	assign expire  = rd_rem == COUNT_WIDTH'(1);
	assign push    = (state_q == ST_SCAN) && expire && (cnt_q < RCNT_W'(MAX_RESULTS));
	assign stall   = push && !res_sts.room;
	assign advance = (state_q == ST_SCAN) && !stall;
	assign more    = rd_cnt_q < scan_len;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (advance && !more) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (res_sts.room) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = state_q == ST_IDLE;
		rd_en         = 1'b0;
		rd_addr       = IDX_W'(rd_cnt_q);
		rem_we        = 1'b0;
		rld_we        = 1'b0;
		wr_addr       = IDX_W'(idx_s1_q);
		wr_rem        = '0;
		wr_rld        = COUNT_WIDTH'(interval);
		res_req.push  = 1'b0;
		res_req.flush = 1'b0;
		res_req.idx   = OUT_IDX_W'(idx_s1_q);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					rd_en   = 1'b1;
					rd_addr = '0;
				end else if (in_acc && idx_ok && (func == FN_ARM)) begin
					rem_we  = 1'b1;
					rld_we  = 1'b1;
					wr_addr = IDX_W'(timer_index);
					wr_rem  = COUNT_WIDTH'(timeout);
				end else if (in_acc && idx_ok && (func == FN_DISARM)) begin
					rem_we  = 1'b1;
					wr_addr = IDX_W'(timer_index);
				end
			end
			ST_SCAN: begin
				res_req.push = push;
				if (advance) begin
					rem_we = nz;
					wr_rem = expire ? rd_rld : rd_rem - COUNT_WIDTH'(1);
					rd_en  = more;
				end
			end
			ST_FLUSH: begin
				res_req.flush = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_cnt_q <= '0;
			idx_s1_q <= '0;
			cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (start) begin
				rd_cnt_q <= TIU_W'(1);
				idx_s1_q <= '0;
				cnt_q    <= '0;
			end else if (advance) begin
				if (push) begin
					cnt_q <= cnt_q + RCNT_W'(1);
				end
				if (more) begin
					idx_s1_q <= rd_cnt_q;
					rd_cnt_q <= rd_cnt_q + TIU_W'(1);
				end
			end
		end
	end

endmodule

@@ hdl/ptb_out.sv @@
// Result stage: one pending word plus the output register, so last is known.
// Depends on ptb_pkg.
module ptb_out import ptb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  res_req_t             res_req,
	output res_sts_t             res_sts,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [OUT_IDX_W-1:0] expired_timer,
	output logic                 last
);

	logic                 pend_valid_q;
	logic [OUT_IDX_W-1:0] pend_idx_q;
	logic                 out_valid_q;
	logic [OUT_IDX_W-1:0] out_idx_q;
	logic                 out_last_q;
	logic                 out_free;
	logic                 move;

	assign out_free     = !out_valid_q || out_ready;
	assign move         = pend_valid_q && out_free && (res_req.push || res_req.flush);
	assign res_sts.room = !pend_valid_q || out_free;
	assign res_sts.pend = pend_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (res_req.push && res_sts.room) begin
				pend_valid_q <= 1'b1;
			end else if (move) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_idx_q  <= pend_idx_q;
			out_last_q <= res_req.flush;
		end
		if (res_req.push && res_sts.room) begin
			pend_idx_q <= res_req.idx;
		end
	end

	assign out_valid     = out_valid_q;
	assign expired_timer = out_idx_q;
	assign last          = out_last_q;

endmodule

@@ bench/tb_periodic_timer_bank_core.sv @@
`timescale 1ns / 100ps
// Self-checking bench for periodic_timer_bank_core: directed, pressure and random words.
// Depends on ptb_pkg and the periodic_timer_bank_core RTL.

typedef struct {
	logic [ptb_pkg::OUT_IDX_W-1:0] timer;
	logic                          last_flag;
} expiry_t;

class expiry_scoreboard;
	localparam int BANK = 16;

	logic [ptb_pkg::FIELD_W-1:0] count_left[BANK];
	logic [ptb_pkg::FIELD_W-1:0] reload_value[BANK];
	logic [ptb_pkg::TIU_W-1:0]   scan_len;
	expiry_t                     due_expiries[$];
	int unsigned                 errors;

	function new();
		foreach (count_left[k]) begin
			count_left[k]   = '0;
			reload_value[k] = '0;
		end
		scan_len = '0;
		errors   = 0;
	endfunction

	function void set_scan_len(logic [ptb_pkg::TIU_W-1:0] v);
		scan_len = v;
	endfunction

	// Advance the bank by one accepted word and queue the expiries it causes.
	function void note_word(logic [1:0] code, logic [3:0] idx,
			logic [ptb_pkg::FIELD_W-1:0] t, logic [ptb_pkg::FIELD_W-1:0] iv);
		int unsigned n_scan;
		int unsigned hits;
		expiry_t     e;
		case (code)
			ptb_pkg::FN_ARM: begin
				count_left[idx]   = t;
				reload_value[idx] = iv;
			end
			ptb_pkg::FN_DISARM: begin
				count_left[idx] = '0;
			end
			ptb_pkg::FN_TICK: begin
				n_scan = (scan_len > BANK) ? BANK : scan_len;
				hits   = 0;
				for (int k = 0; k < n_scan; k++) begin
					if (count_left[k] != 0) begin
						count_left[k] = count_left[k] - 1'b1;
						if (count_left[k] == 0) begin
							if (hits < ptb_pkg::MAX_RESULTS) begin
								e.timer     = 4'(k);
								e.last_flag = 1'b0;
								due_expiries.push_back(e);
								hits++;
							end
							count_left[k] = reload_value[k];
						end
					end
				end
				if (hits > 0)
					due_expiries[due_expiries.size() - 1].last_flag = 1'b1;
			end
			default: ;
		endcase
	endfunction

	function void check_expiry(logic [3:0] timer, logic last_flag);
		expiry_t want;
		if (due_expiries.size() == 0) begin
			$error("unexpected word: expired_timer=%0d last=%0b", timer, last_flag);
			errors++;
			return;
		end
		want = due_expiries.pop_front();
		if (timer !== want.timer) begin
			$error("expired_timer: expected %0d, actual %0d", want.timer, timer);
			errors++;
		end
		if (last_flag !== want.last_flag) begin
			$error("last: expected %0b, actual %0b", want.last_flag, last_flag);
			errors++;
		end
	endfunction
endclass

module tb_periodic_timer_bank_core;
	import ptb_pkg::*;

	// Operation code that the bank must ignore.
	localparam logic [1:0] FN_UNUSED = 2'd3;
	// Idle cycles after the last expected word before a register write or the end,
	// long enough to cover a full tick scan with no expiry.
	localparam int SETTLE_CYCLES = 40;
	// Long receiver hold-off that lets the bank fill up and stall its input.
	localparam int RX_HOLD_CYCLES = 300;
	localparam int RANDOM_PHASES = 6;
	localparam int WORDS_PER_PHASE = 20;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [TIU_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           func;
	logic [3:0]           timer_index;
	logic [FIELD_W-1:0]   timeout;
	logic [FIELD_W-1:0]   interval;
	logic                 out_valid;
	logic                 out_ready;
	logic [OUT_IDX_W-1:0] expired_timer;
	logic                 last;

	expiry_scoreboard sb = new();

	// Calm: neither side idles. Hold requests are counted so the receiver
	// process can pick them up on its own edge.
	bit          calm;
	int unsigned holds_asked;
	int unsigned holds_done;

	periodic_timer_bank_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.timer_index   (timer_index),
		.timeout       (timeout),
		.interval      (interval),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.expired_timer (expired_timer),
		.last          (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the bank hangs; far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("tb_periodic_timer_bank_core NOT OK");
		$finish;
	end

	// Monitor: sample both handshakes on the edge, before any driver update lands.
	// Check the outgoing word first; a tick accepted on this edge cannot have
	// produced a word yet, so the order against the input note does not matter.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_expiry(expired_timer, last);
			if (in_valid && in_ready)
				sb.note_word(func, timer_index, timeout, interval);
		end
	end

	// Receiver: drop ready at random with a 7 percent chance, or hold it low for a long
	// stretch whenever the stimulus asks for one.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (holds_asked != holds_done) begin
				out_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
				holds_done++;
			end else begin
				out_ready <= calm || ($urandom_range(0, 99) >= 7);
			end
		end
	end

	// Offer one word and hold it until accepted. Called on a clock edge, returns
	// on the accepting edge with valid still high, so the next call can replace
	// the payload without lowering valid in between.
	task automatic send_word(input logic [1:0] code, input logic [3:0] idx,
			input logic [FIELD_W-1:0] t, input logic [FIELD_W-1:0] iv);
		if (!calm && $urandom_range(0, 99) < 7) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= code;
		timer_index <= idx;
		timeout     <= t;
		interval    <= iv;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop offering, wait for every expected word, then let a tick with no
	// expiry finish its scan.
	task automatic wait_bank_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.due_expiries.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only call with the bank idle.
	task automatic write_scan_len(input logic [TIU_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_scan_len(v);
	endtask

	// Mostly ticks and arms with short counts so timers keep expiring; now and
	// then a full-range count, a disarm or an unused code with random payload.
	task automatic send_random_word();
		int unsigned pick;
		logic [FIELD_W-1:0] t;
		logic [FIELD_W-1:0] iv;
		pick = $urandom_range(0, 99);
		t    = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom;
		iv   = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 5) : $urandom;
		if (pick < 40)
			send_word(FN_TICK, 4'($urandom), $urandom, $urandom);
		else if (pick < 75)
			send_word(FN_ARM, 4'($urandom), t, iv);
		else if (pick < 92)
			send_word(FN_DISARM, 4'($urandom), $urandom, $urandom);
		else
			send_word(FN_UNUSED, 4'($urandom), $urandom, $urandom);
	endtask

	initial begin
		logic [TIU_W-1:0] phase_len[RANDOM_PHASES];

		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		func        = FN_TICK;
		timer_index = '0;
		timeout     = '0;
		interval    = '0;
		calm        = 1'b0;
		holds_asked = 0;
		holds_done  = 0;
		phase_len   = '{5'd31, 5'd1, 5'd17, 5'd8, 5'd16, 5'd0};
		phase_len[RANDOM_PHASES - 1] = 5'($urandom_range(0, 31));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: full bank scanned.
		write_scan_len(5'd16);
		// Unused code with every payload bit set: no effect.
		send_word(FN_UNUSED, 4'd15, '1, '1);
		// One-shot, periodic, never-expiring and zero-timeout arms.
		send_word(FN_ARM, 4'd0, 32'd1, 32'd0);
		send_word(FN_ARM, 4'd15, 32'd2, 32'd3);
		send_word(FN_ARM, 4'd7, '1, '1);
		send_word(FN_ARM, 4'd3, 32'd0, 32'd5);
		send_word(FN_TICK, 4'd0, '0, '0);
		send_word(FN_TICK, 4'd15, '1, '1);
		send_word(FN_TICK, 4'd0, '0, '0);
		send_word(FN_ARM, 4'd5, 32'd1, 32'd1);
		send_word(FN_ARM, 4'd9, 32'd1, 32'd0);
		send_word(FN_TICK, 4'd0, '0, '0);
		send_word(FN_TICK, 4'd0, '0, '0);
		send_word(FN_DISARM, 4'd7, '1, '1);
		send_word(FN_DISARM, 4'd15, '0, '0);
		send_word(FN_TICK, 4'd0, '0, '0);
		send_word(FN_UNUSED, 4'd0, '0, '0);

		// Empty scan: counts freeze.
		wait_bank_idle();
		write_scan_len(5'd0);
		send_word(FN_TICK, 4'd0, '0, '0);
		send_word(FN_TICK, 4'd0, '0, '0);

		// Scan length beyond the bank clamps to all sixteen.
		wait_bank_idle();
		write_scan_len(5'd31);
		send_word(FN_ARM, 4'd14, 32'd1, 32'd2);
		send_word(FN_TICK, 4'd0, '0, '0);
		send_word(FN_TICK, 4'd0, '0, '0);

		// Random phases, each under its own scan length; the third runs calm.
		for (int p = 0; p < RANDOM_PHASES - 1; p++) begin
			wait_bank_idle();
			write_scan_len(phase_len[p]);
			calm = (p == 2);
			repeat (WORDS_PER_PHASE) send_random_word();
		end
		calm = 1'b0;

		// Pressure: every timer expires on every tick while the receiver holds
		// off, so the bank backs up and stalls its input.
		wait_bank_idle();
		write_scan_len(5'd16);
		for (int k = 0; k < 16; k++)
			send_word(FN_ARM, 4'(k), 32'd1, 32'd1);
		holds_asked++;
		repeat (12) send_word(FN_TICK, 4'($urandom), $urandom, $urandom);

		// Pause until every expected word is out, then one last random phase.
		wait_bank_idle();
		write_scan_len(phase_len[RANDOM_PHASES - 1]);
		repeat (WORDS_PER_PHASE) send_random_word();

		wait_bank_idle();
		if (sb.errors == 0 && sb.due_expiries.size() == 0)
			$display("tb_periodic_timer_bank_core OK");
		else
			$display("tb_periodic_timer_bank_core NOT OK");
		$finish;
	end

endmodule
